[design/msub_pkg.sv]
// ----------------------------------------------------------------------------
// msub_pkg: shared types and constants for the message subscription table
// Request codes, controller/datapath handshake structs and the key hash.
// ----------------------------------------------------------------------------
package msub_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int KEY_W          = 8;
	localparam logic [KEY_W-1:0] EMPTY_KEY = 8'hFF;
	localparam int OUT_DATA_W     = 16;

	typedef enum logic [1:0] {
		REQ_SUB_FRONT = 2'd0,
		REQ_SUB_BACK  = 2'd1,
		REQ_LKP_FRONT = 2'd2,
		REQ_LKP_BACK  = 2'd3
	} req_t;

	// controller to datapath
	typedef struct packed {
		logic in_rdy;
		logic rd_en;
		logic step;
		logic wr_en;
		logic finish;
		logic res_ok;
		logic out_load;
	} msub_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_fire;
		logic short_done;
		logic store_mode;
		logic entry_match;
		logic entry_empty;
		logic last;
		logic out_free;
	} msub_sts_t;

	// key mod 7: 64 and 8 are both 1 mod 7, so sum the octal digits and fold
	function automatic logic [2:0] key_mod7(input logic [KEY_W-1:0] k);
		logic [4:0] s;
		s = {3'b000, k[7:6]} + {2'b00, k[5:3]} + {2'b00, k[2:0]};
		if (s >= 5'd14) begin
			s = s - 5'd14;
		end else if (s >= 5'd7) begin
			s = s - 5'd7;
		end
		return s[2:0];
	endfunction

endpackage

[design/msub_ram.sv]
// ----------------------------------------------------------------------------
// msub_ram: generic single-port ram
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module msub_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic                                     re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
	input  logic [Width-1:0]                         wdata,
	output logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[design/msub_ctrl.sv]
// ----------------------------------------------------------------------------
// msub_ctrl: request sequencer
// Walks the slot scan one entry at a time and decides store, hit or miss.
// ----------------------------------------------------------------------------
module msub_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msub_pkg::msub_sts_t  sts,
	output msub_pkg::msub_cmd_t  cmd
);
	import msub_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_rdy = 1'b1;
				if (sts.in_fire) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.short_done) begin
					cmd.finish = 1'b1;
					cmd.res_ok = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.store_mode) begin
					if (sts.entry_match) begin
						cmd.finish = 1'b1;
						cmd.res_ok = 1'b1;
						state_d    = ST_EMIT;
					end else if (sts.entry_empty) begin
						cmd.wr_en  = 1'b1;
						cmd.finish = 1'b1;
						cmd.res_ok = 1'b1;
						state_d    = ST_EMIT;
					end else if (sts.last) begin
						cmd.finish = 1'b1;
						state_d    = ST_EMIT;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_READ;
					end
				end else begin
					// lookups stop with a miss at the first empty slot
					if (sts.entry_empty) begin
						cmd.finish = 1'b1;
						state_d    = ST_EMIT;
					end else if (sts.entry_match) begin
						cmd.finish = 1'b1;
						cmd.res_ok = 1'b1;
						state_d    = ST_EMIT;
					end else if (sts.last) begin
						cmd.finish = 1'b1;
						state_d    = ST_EMIT;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_READ;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/msub_dp.sv]
// ----------------------------------------------------------------------------
// msub_dp: table datapath
// Request registers, scan index, slot ram with valid flags, hash filter
// and the result register on the master side.
// ----------------------------------------------------------------------------
module msub_dp #(
	parameter int SlotCount = msub_pkg::SLOT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msub_pkg::msub_cmd_t                 cmd,
	output msub_pkg::msub_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic                                cfg_wdata,
	input  logic                                s_tvalid,
	input  logic [2:0]                          s_tuser,
	input  logic [6:0]                          s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [msub_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import msub_pkg::*;

	localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
	localparam logic [IdxW-1:0] IdxLast = IdxW'(SlotCount - 1);

	req_t             req_q;
	logic [KEY_W-1:0] key_q;
	logic [IdxW-1:0]  idx_q;
	logic [SlotCount-1:0] vld_q;
	logic             vld_rd_q;
	logic [KEY_W-1:0] ram_rdata;
	logic [KEY_W-1:0] entry;
	logic [KEY_W-1:0] in_key;
	req_t             in_req;
	logic             accept_all_q;
	logic [7:0]       filter_q;
	logic             ok_q;
	logic             chg_q;
	logic             m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic             is_back;
	logic             in_fire;

	assign in_fire = s_tvalid && cmd.in_rdy;
	// tuser: req_type in bits 1:0, kind in bit 2
	assign in_req  = req_t'(s_tuser[1:0]);
	assign in_key  = {s_tuser[2], s_tdata};
	assign is_back = (req_q == REQ_SUB_BACK) || (req_q == REQ_LKP_BACK);

	msub_ram #(
		.Width (KEY_W),
		.Depth (SlotCount)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.re    (cmd.rd_en),
		.addr  (idx_q),
		.wdata (key_q),
		.rdata (ram_rdata)
	);

	// never-written slots read as empty
	assign entry = vld_rd_q ? ram_rdata : EMPTY_KEY;

	always_comb begin
		sts             = '0;
		sts.in_fire     = in_fire;
		sts.store_mode  = (req_q == REQ_SUB_FRONT) || (req_q == REQ_SUB_BACK);
		sts.short_done  = (sts.store_mode && (key_q == EMPTY_KEY))
			|| ((req_q == REQ_LKP_FRONT) && accept_all_q);
		sts.entry_match = (entry == key_q);
		sts.entry_empty = (entry == EMPTY_KEY);
		sts.last        = is_back ? (idx_q == '0) : (idx_q == IdxLast);
		sts.out_free    = !m_tvalid_q || m_tready;
	end

	// request and scan index
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_req;
			key_q <= in_key;
			if ((in_req == REQ_SUB_BACK) || (in_req == REQ_LKP_BACK)) begin
				idx_q <= IdxLast;
			end else begin
				idx_q <= '0;
			end
		end else if (cmd.step) begin
			idx_q <= is_back ? (idx_q - IdxW'(1)) : (idx_q + IdxW'(1));
		end
		if (cmd.finish) begin
			ok_q  <= cmd.res_ok;
			chg_q <= cmd.wr_en && (req_q == REQ_SUB_FRONT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (cmd.rd_en) begin
				vld_rd_q <= vld_q[idx_q];
			end
		end
	end

	// config and hash filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_all_q <= 1'b0;
			filter_q     <= '0;
		end else begin
			if (cfg_we) begin
				accept_all_q <= cfg_wdata;
			end
			if (cfg_we && cfg_wdata) begin
				filter_q <= 8'hFF;
			end else if (in_fire && (in_req == REQ_SUB_FRONT)) begin
				filter_q <= filter_q | (8'b1 << key_mod7(in_key));
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {6'b0, chg_q, (accept_all_q ? 8'hFF : filter_q), ok_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[design/message_subscription_table_core.sv]
// empty-marker subscribes and front lookups under accept_all skip the scan; other
// requests read and compare the slots in turn, ST_READ then ST_CMP for each slot
// one request at a time: a new request is accepted only after the last result
// is loaded, and the scan goes one entry per read through the single-port slot ram
// reset: slot valid flags, hash filter and accept_all clear at once, so the
// table reads as all empty right after reset with no clearing pass
// ----------------------------------------------------------------------------
// message_subscription_table_core: packet subscription table
// Subscribe and lookup of 8-bit message keys with an 8-bit hash filter.
// ----------------------------------------------------------------------------
module message_subscription_table_core #(
	parameter int SlotCount = msub_pkg::SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,     // accept_all
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,       // msg_id[6:0]
	input  logic [2:0]                      s_tuser,       // req_type[1:0], kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [msub_pkg::OUT_DATA_W-1:0] m_tdata        // ok, filter_bits, filter_changed
);
	import msub_pkg::*;

	msub_cmd_t cmd;
	msub_sts_t sts;

	msub_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	msub_dp #(
		.SlotCount (SlotCount)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata[6:0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	assign s_tready = cmd.in_rdy;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for message_subscription_table_core
// Drives subscribe and lookup requests in random bursts while the result side
// stalls on its own pattern, predicts every result with a scoreboard that
// tracks the slot table and hash filter, and walks accept_all through 0 and 1.
// ----------------------------------------------------------------------------
module tb;
	import msub_pkg::*;

	localparam int SLOTS      = SLOT_COUNT_DEF;
	localparam int HASH_MOD   = 7;
	localparam int POOL       = 20;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		bit       ok;
		bit [7:0] filter;
		bit       changed;
	} response_t;

	class subscription_scoreboard;
		bit [7:0]  slots[SLOTS];
		bit [7:0]  hash_filter;
		bit        accept_all;
		response_t expected_q[$];
		int        errors;
		int        results_seen;

		function new();
			foreach (slots[i]) slots[i] = EMPTY_KEY;
			hash_filter = '0;
			accept_all = 1'b0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_accept_all(bit v);
			accept_all = v;
			if (v) hash_filter = 8'hFF;
		endfunction

		// walk the table; subscribes claim the first empty slot, lookups stop there
		function bit scan(bit [7:0] key, bit downward, bit claim, output bit stored);
			int idx;
			stored = 1'b0;
			for (int n = 0; n < SLOTS; n++) begin
				idx = downward ? SLOTS - 1 - n : n;
				if (claim) begin
					if (slots[idx] == key) return 1'b1;
					if (slots[idx] == EMPTY_KEY) begin
						slots[idx] = key;
						stored = 1'b1;
						return 1'b1;
					end
				end else begin
					if (slots[idx] == EMPTY_KEY) return 1'b0;
					if (slots[idx] == key) return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(req_t req, bit [7:0] key);
			response_t exp;
			bit        stored;
			exp.ok = 1'b0;
			exp.changed = 1'b0;
			case (req)
				REQ_SUB_FRONT: begin
					hash_filter |= 8'(1 << (key % HASH_MOD));
					if (key == EMPTY_KEY) begin
						exp.ok = 1'b1;
					end else begin
						exp.ok = scan(key, 1'b0, 1'b1, stored);
						exp.changed = stored;
					end
				end
				REQ_SUB_BACK: begin
					exp.ok = (key == EMPTY_KEY) ? 1'b1 : scan(key, 1'b1, 1'b1, stored);
				end
				REQ_LKP_FRONT: begin
					exp.ok = accept_all ? 1'b1 : scan(key, 1'b0, 1'b0, stored);
				end
				default: begin
					exp.ok = scan(key, 1'b1, 1'b0, stored);
				end
			endcase
			exp.filter = accept_all ? 8'hFF : hash_filter;
			expected_q.push_back(exp);
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH %s: got %0h expected %0h (result %0d)",
				what, got, want, results_seen);
			errors++;
		endtask

		task check_result(logic [OUT_DATA_W-1:0] data);
			response_t exp;
			results_seen++;
			if (expected_q.size() == 0) begin
				report("unexpected beat", data, 0);
				return;
			end
			exp = expected_q.pop_front();
			if (data[0] !== exp.ok) report("ok", data[0], exp.ok);
			if (data[8:1] !== exp.filter) report("filter_bits", data[8:1], exp.filter);
			if (data[9] !== exp.changed) report("filter_changed", data[9], exp.changed);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_wdata = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;     // msg_id[6:0]
	logic [2:0]            s_tuser = '0;     // req_type[1:0], kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // ok, filter_bits, filter_changed

	subscription_scoreboard sb = new;

	bit [7:0] key_pool[POOL];
	int       burst_left = 0;
	int       random_issued = 0;
	int       idle_cycles = 0;

	message_subscription_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// monitor, scoreboard hookup and watchdog
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sb.note_request(req_t'(s_tuser[1:0]), {s_tuser[2], s_tdata[6:0]});
		end
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side stalls in spans of varying character, plus one long hold-off
	initial begin
		int mode;
		int span;
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 80);
			repeat (span) begin
				@(posedge clk);
				if (!held && sb.results_seen >= 150) begin
					held = 1'b1;
					hold = 500;
				end
				if (hold > 0) begin
					hold--;
					m_tready <= 1'b0;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 4) == 0);
						default: m_tready <= ~m_tready;
					endcase
				end
			end
		end
	end

	task automatic offer_request(req_t req, bit [7:0] key);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= {key[7], req};
		s_tdata  <= {1'b0, key[6:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_accept_all(bit v);
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.set_accept_all(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly keys from a pool that widens over time, so the table fills slowly
	task automatic offer_random_requests(int count);
		int       pick;
		int       bound;
		bit [7:0] key;
		req_t     req;
		for (int i = 0; i < count; i++) begin
			bound = (random_issued / 70 < POOL) ? random_issued / 70 : POOL - 1;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				req = $urandom_range(0, 1) ? REQ_SUB_BACK : REQ_SUB_FRONT;
			end else begin
				req = $urandom_range(0, 1) ? REQ_LKP_BACK : REQ_LKP_FRONT;
			end
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				key = EMPTY_KEY;
			end else if (pick < 6 || (pick < 22 && (req == REQ_LKP_FRONT ||
					req == REQ_LKP_BACK))) begin
				key = 8'($urandom_range(0, 255));
			end else begin
				key = key_pool[$urandom_range(0, bound)];
			end
			offer_request(req, key);
			random_issued++;
		end
	endtask

	initial begin
		int  filled;
		bit  dup;
		bit [7:0] cand;
		filled = 0;
		while (filled < POOL) begin
			cand = 8'($urandom_range(0, 254));
			dup = 1'b0;
			for (int j = 0; j < filled; j++) if (key_pool[j] == cand) dup = 1'b1;
			if (!dup) begin
				key_pool[filled] = cand;
				filled++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, empty-marker key, both scan directions
		offer_request(REQ_LKP_FRONT, 8'h00);
		offer_request(REQ_LKP_BACK,  EMPTY_KEY);
		offer_request(REQ_SUB_FRONT, EMPTY_KEY);
		offer_request(REQ_SUB_BACK,  EMPTY_KEY);
		offer_request(REQ_SUB_FRONT, 8'h00);
		offer_request(REQ_SUB_FRONT, 8'h00);
		offer_request(REQ_SUB_BACK,  8'hFE);
		offer_request(REQ_LKP_FRONT, 8'hFE);   // misses on the gap before slot 15
		offer_request(REQ_LKP_BACK,  8'hFE);
		offer_request(REQ_LKP_BACK,  8'h00);
		offer_request(REQ_LKP_FRONT, 8'h00);
		offer_request(REQ_SUB_FRONT, 8'h7F);
		offer_request(REQ_SUB_FRONT, 8'h80);
		offer_request(REQ_SUB_BACK,  8'hFE);
		offer_request(REQ_LKP_FRONT, EMPTY_KEY);

		offer_random_requests(800);

		write_accept_all(1'b1);
		offer_request(REQ_LKP_FRONT, EMPTY_KEY);
		offer_request(REQ_LKP_BACK,  EMPTY_KEY);
		offer_request(REQ_LKP_FRONT, 8'h3C);
		offer_request(REQ_SUB_FRONT, 8'h3C);
		offer_request(REQ_LKP_BACK,  8'h00);
		offer_random_requests(500);

		// filter stays all ones after clearing
		write_accept_all(1'b0);
		offer_random_requests(480);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[message_subscription_table_core.f]
design/msub_pkg.sv
design/msub_ram.sv
design/msub_ctrl.sv
design/msub_dp.sv
design/message_subscription_table_core.sv
test/tb.sv
